// File: rtl/core/magcpc_pkg.sv
// Shared types and constants of the magnetometer calibration point collector.
package magcpc_pkg;

  localparam int NUM_AXES  = 3;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int PTS_W     = 3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SAMPLE_COUNT = 2'd0;
  localparam logic [1:0] CFG_MOVE_THRESH  = 2'd1;
  localparam logic [1:0] CFG_POS_TIMEOUT  = 2'd2;

  // Calibration mode codes as reported on the result channel.
  localparam logic [1:0] MODE_READY   = 2'd0;
  localparam logic [1:0] MODE_COLLECT = 2'd1;
  localparam logic [1:0] MODE_WAIT    = 2'd2;

  typedef struct packed {
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
    logic               device_still;
    logic               start_request;
    logic [31:0]        now_ticks;
  } in_item_t;

  typedef struct packed {
    logic               updated;
    logic [1:0]         mode;
    logic               point_valid;
    logic [1:0]         point_index;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    logic signed [15:0] point_z;
    logic               run_done;
    logic               run_aborted;
    logic               clear_request;
  } res_t;

  // Per-axis lane commands issued by the controller.
  typedef struct packed {
    logic clear_sum;
    logic add_sum;
    logic div_load;
    logic div_step;
    logic store_point;
  } lane_ctrl_t;

endpackage

// File: rtl/core/magcpc_in_if.sv
// Input sample channel interface.
interface magcpc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  logic               device_still;
  logic               start_request;
  logic [31:0]        now_ticks;

  modport source (output valid, mag_x, mag_y, mag_z, device_still, start_request,
                  now_ticks, input ready);
  modport sink (input valid, mag_x, mag_y, mag_z, device_still, start_request,
                now_ticks, output ready);
endinterface

// File: rtl/core/magcpc_out_if.sv
// Result channel interface.
interface magcpc_out_if;
  logic               valid;
  logic               ready;
  logic               updated;
  logic [1:0]         mode;
  logic               point_valid;
  logic [1:0]         point_index;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;
  logic               run_done;
  logic               run_aborted;
  logic               clear_request;

  modport source (output valid, updated, mode, point_valid, point_index, point_x,
                  point_y, point_z, run_done, run_aborted, clear_request, input ready);
  modport sink (input valid, updated, mode, point_valid, point_index, point_x,
                point_y, point_z, run_done, run_aborted, clear_request, output ready);
endinterface

// File: rtl/core/magcpc_lane.sv
// One axis lane: running sum, bit-serial averaging divider, last point and squared offset.
module magcpc_lane
  import magcpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  lane_ctrl_t         ctrl,
  input  logic signed [15:0] sample,
  input  logic [16:0]        divisor,
  output logic signed [15:0] point,
  output logic [31:0]        sq
);

  logic [31:0]        sum_r;
  logic               neg_r;
  logic [31:0]        quo_r;
  logic [16:0]        rem_r;
  logic signed [15:0] last_r;
  logic [31:0]        sq_r;

  logic [17:0]        trial;
  logic               fits;
  logic [17:0]        diff;
  logic signed [16:0] df;
  logic signed [33:0] prod;

  // Running sum of still samples, wrapping in 32 bits.
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_sum) begin
      sum_r <= '0;
    end else if (ctrl.add_sum) begin
      sum_r <= sum_r + {{16{sample[15]}}, sample};
    end
  end

  // Restoring division of the sum magnitude, one quotient bit per cycle.
  assign trial = {rem_r, quo_r[31]};
  assign fits  = trial >= {1'b0, divisor};
  assign diff  = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (ctrl.div_load) begin
      neg_r <= sum_r[31];
      quo_r <= sum_r[31] ? (~sum_r + 32'd1) : sum_r;
      rem_r <= '0;
    end else if (ctrl.div_step) begin
      rem_r <= fits ? diff[16:0] : trial[16:0];
      quo_r <= {quo_r[30:0], fits};
    end
  end

  // Sign restore with saturation to the 16-bit range.
  always_comb begin
    if (!neg_r) begin
      point = (quo_r > 32'd32767) ? 16'sh7FFF : $signed(quo_r[15:0]);
    end else begin
      point = (quo_r > 32'd32768) ? 16'sh8000 : $signed(~quo_r[15:0] + 16'd1);
    end
  end

  // Last stored point and squared offset of the current sample from it.
  always_ff @(posedge clk) begin
    if (ctrl.store_point) begin
      last_r <= point;
    end
  end

  assign df   = $signed({last_r[15], last_r}) - $signed({sample[15], sample});
  assign prod = df * df;

  always_ff @(posedge clk) begin
    sq_r <= prod[31:0];
  end

  assign sq = sq_r;

endmodule

// File: rtl/core/magcpc_merge.sv
// Merging stage: adds the lane squares and compares against the square of the threshold plus one.
module magcpc_merge
  import magcpc_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] sq [NUM_AXES],
  input  logic [15:0] threshold,
  output logic        moved
);

  logic [33:0] dist_r;
  logic [33:0] lim_sq_r;
  logic [16:0] lim;
  logic [33:0] lim_prod;

  assign lim      = {1'b0, threshold} + 17'd1;
  assign lim_prod = lim * lim;

  // Squared distance and squared limit, registered ahead of the compare.
  always_ff @(posedge clk) begin
    dist_r   <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]};
    lim_sq_r <= lim_prod;
  end

  assign moved = dist_r >= lim_sq_r;

endmodule

// File: rtl/core/mag_calibration_point_collector.sv
// Top level: control sequencer, three axis lanes, merging stage and output register.
// Result path: an accepted item passes evaluation, then the emit step; in waiting mode
// the two wait steps come between, and for a completed point the lanes' 32-step divider.
// Throughput: one item at a time; the next is accepted once the current result
// moves to the output register.
// Reset (synchronous, rst_n low): ready mode, registers to their defaults, no result.
module mag_calibration_point_collector
  import magcpc_pkg::*;
#(
  parameter int NUM_POINTS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  magcpc_in_if.sink           in_ch,
  magcpc_out_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_EVAL, S_WAIT1, S_WAIT2, S_DLOAD, S_DIV, S_FIN, S_EMIT
  } state_t;

  state_t               state_r;
  logic [15:0]          sample_count_r;
  logic [15:0]          move_threshold_r;
  logic [31:0]          position_timeout_r;
  logic [1:0]           mode_r;
  logic [15:0]          samples_left_r;
  logic [PTS_W-1:0]     points_done_r;
  logic [31:0]          deadline_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  in_item_t             in_r;
  res_t                 res_r;
  res_t                 out_res_r;
  logic                 out_valid_r;

  logic [15:0]          samples_left_nxt;
  logic [PTS_W:0]       points_next;
  logic [16:0]          divisor;
  lane_ctrl_t           lane_ctrl;
  logic signed [15:0]   sample [NUM_AXES];
  logic signed [15:0]   point [NUM_AXES];
  logic [31:0]          sq [NUM_AXES];
  logic                 moved;
  logic                 in_fire;
  logic                 can_emit;
  res_t                 eval_res;

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign can_emit    = !out_valid_r || out_ch.ready;

  // A zero sample count stands for 65536 samples.
  assign divisor = (sample_count_r == 16'd0) ? 17'h10000 : {1'b0, sample_count_r};
  assign samples_left_nxt = in_r.device_still ? (samples_left_r - 16'd1) : sample_count_r;
  assign points_next = {1'b0, points_done_r} + {{PTS_W{1'b0}}, 1'b1};

  assign sample[0] = in_r.mag_x;
  assign sample[1] = in_r.mag_y;
  assign sample[2] = in_r.mag_z;

  // Result fields known after the first evaluation step.
  always_comb begin
    eval_res         = '0;
    eval_res.updated = 1'b1;
    eval_res.mode    = MODE_COLLECT;
    if (mode_r == MODE_WAIT) begin
      eval_res.mode = MODE_WAIT;
    end else if (mode_r != MODE_COLLECT && !in_r.start_request) begin
      eval_res.updated = 1'b0;
      eval_res.mode    = MODE_READY;
    end
  end

  // Lane commands for each sequencer step.
  always_comb begin
    lane_ctrl = '0;
    case (state_r)
      S_EVAL: begin
        if (mode_r == MODE_COLLECT) begin
          lane_ctrl.add_sum   = in_r.device_still;
          lane_ctrl.clear_sum = !in_r.device_still;
        end else if (mode_r != MODE_WAIT) begin
          lane_ctrl.clear_sum = in_r.start_request;
        end
      end
      S_WAIT2: lane_ctrl.clear_sum   = 1'b1;
      S_DLOAD: lane_ctrl.div_load    = 1'b1;
      S_DIV:   lane_ctrl.div_step    = 1'b1;
      S_FIN:   lane_ctrl.store_point = 1'b1;
      default: lane_ctrl = '0;
    endcase
  end

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    magcpc_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl),
      .sample  (sample[a]),
      .divisor (divisor),
      .point   (point[a]),
      .sq      (sq[a])
    );
  end

  magcpc_merge u_merge (
    .clk       (clk),
    .sq        (sq),
    .threshold (move_threshold_r),
    .moved     (moved)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r     <= 16'd1024;
      move_threshold_r   <= 16'd175;
      position_timeout_r <= 32'd60000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_COUNT: sample_count_r     <= cfg_data[15:0];
        CFG_MOVE_THRESH:  move_threshold_r   <= cfg_data[15:0];
        CFG_POS_TIMEOUT:  position_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer with calibration state and the result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      mode_r         <= MODE_READY;
      samples_left_r <= 16'd1024;
      points_done_r  <= '0;
      deadline_r     <= '0;
      div_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // In the emit step the output register is reloaded instead.
      if (out_valid_r && out_ch.ready && state_r != S_EMIT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            in_r.mag_x         <= in_ch.mag_x;
            in_r.mag_y         <= in_ch.mag_y;
            in_r.mag_z         <= in_ch.mag_z;
            in_r.device_still  <= in_ch.device_still;
            in_r.start_request <= in_ch.start_request;
            in_r.now_ticks     <= in_ch.now_ticks;
            state_r            <= S_EVAL;
          end
        end
        S_EVAL: begin
          res_r <= eval_res;
          if (mode_r == MODE_COLLECT) begin
            samples_left_r <= samples_left_nxt;
            if (samples_left_nxt == 16'd0) begin
              deadline_r <= in_r.now_ticks + position_timeout_r;
              state_r    <= S_DLOAD;
            end else begin
              state_r <= S_EMIT;
            end
          end else if (mode_r == MODE_WAIT) begin
            state_r <= S_WAIT1;
          end else begin
            // Ready mode, and the unused code, which acts as ready.
            if (in_r.start_request) begin
              points_done_r  <= '0;
              samples_left_r <= sample_count_r;
              mode_r         <= MODE_COLLECT;
            end else begin
              mode_r <= MODE_READY;
            end
            state_r <= S_EMIT;
          end
        end
        S_WAIT1: state_r <= S_WAIT2;
        S_WAIT2: begin
          samples_left_r <= sample_count_r;
          if (moved) begin
            mode_r     <= MODE_COLLECT;
            res_r.mode <= MODE_COLLECT;
          end else if (in_r.now_ticks > deadline_r) begin
            mode_r              <= MODE_READY;
            res_r.mode          <= MODE_READY;
            res_r.run_aborted   <= 1'b1;
            res_r.clear_request <= 1'b1;
          end else begin
            res_r.mode <= MODE_WAIT;
          end
          state_r <= S_EMIT;
        end
        S_DLOAD: begin
          div_cnt_r <= '0;
          state_r   <= S_DIV;
        end
        S_DIV: begin
          div_cnt_r <= div_cnt_r + 1'b1;
          if (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          res_r.point_valid <= 1'b1;
          res_r.point_index <= points_done_r[1:0];
          res_r.point_x     <= point[0];
          res_r.point_y     <= point[1];
          res_r.point_z     <= point[2];
          points_done_r     <= points_next[PTS_W-1:0];
          if (points_next == (PTS_W + 1)'(NUM_POINTS)) begin
            mode_r              <= MODE_READY;
            res_r.mode          <= MODE_READY;
            res_r.run_done      <= 1'b1;
            res_r.clear_request <= 1'b1;
          end else begin
            mode_r     <= MODE_WAIT;
            res_r.mode <= MODE_WAIT;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (can_emit) begin
            out_res_r   <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Result channel driven from the output register.
  assign out_ch.valid         = out_valid_r;
  assign out_ch.updated       = out_res_r.updated;
  assign out_ch.mode          = out_res_r.mode;
  assign out_ch.point_valid   = out_res_r.point_valid;
  assign out_ch.point_index   = out_res_r.point_index;
  assign out_ch.point_x       = out_res_r.point_x;
  assign out_ch.point_y       = out_res_r.point_y;
  assign out_ch.point_z       = out_res_r.point_z;
  assign out_ch.run_done      = out_res_r.run_done;
  assign out_ch.run_aborted   = out_res_r.run_aborted;
  assign out_ch.clear_request = out_res_r.clear_request;

  // A completed point leaves the block waiting, unless it finished the run.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.point_valid |-> (out_ch.mode == MODE_WAIT) || out_ch.run_done)
    else $error("point result with unexpected mode");

  // An aborted run always returns to ready and asks for the request to clear.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.run_aborted |->
      (out_ch.mode == MODE_READY) && out_ch.clear_request && !out_ch.point_valid)
    else $error("abort result inconsistent");

  // A finished run comes with its last point.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.run_done |-> out_ch.point_valid && out_ch.clear_request)
    else $error("done result without point");

  // Only one transaction is in work at a time.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ch.ready)
    else $error("input accepted while busy");

  // The divider runs only while the controller is in the point-completion path.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (mode_r == MODE_COLLECT))
    else $error("divider active outside collecting mode");

endmodule
